// File: src/base64_stream_encoder_macros.svh
// Assertion macros shared by the base64 stream encoder RTL.
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define B64E_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define B64E_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/b64e_pkg.sv
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
package b64e_pkg;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);
    localparam int QCw    = $clog2(QDepth + 1);

    localparam logic [7:0] PadChar = 8'h3D;

    // Group position of the byte being encoded
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } phase_t;

    // One encoded byte: up to two 6-bit codes, then '=' pads
    typedef struct packed {
        logic [1:0][5:0] code;      // code[0] goes out first
        logic            two_codes; // code[1] is used too
        logic [1:0]      pads;      // number of '=' after the codes
        logic            last;      // final item of the message
    } job_t;

    // Queue occupancy, seen by the top level
    typedef struct packed {
        logic [QCw-1:0] count;
        logic           full;
        logic           empty;
    } q_stat_t;

    // Standard alphabet: A-Z a-z 0-9 + /
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        begin
            w = {2'b00, v};
            if (v < 6'd26) begin
                c = w + 8'd65;
            end else if (v < 6'd52) begin
                c = w + 8'd71;            // 'a' - 26
            end else if (v < 6'd62) begin
                c = w - 8'd4;             // '0' - 52
            end else if (v == 6'd62) begin
                c = 8'h2B;
            end else begin
                c = 8'h2F;
            end
            return c;
        end
    endfunction

endpackage

// File: src/b64e_front.sv
// Front end: tracks the group position and turns each byte into a character job.
module b64e_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,        // byte accepted this cycle
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    output b64e_pkg::job_t job
);
    import b64e_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [3:0] left_reg, left_next;

    // Classify the byte against the current group position
    always_comb begin
        job        = '0;
        job.last   = last_byte;
        phase_next = phase_reg;
        left_next  = left_reg;
        case (phase_reg)
            PH_SECOND: begin
                job.code[0] = {left_reg[1:0], data_byte[7:4]};
                if (last_byte) begin
                    job.code[1]   = {data_byte[3:0], 2'b00};
                    job.two_codes = 1'b1;
                    job.pads      = 2'd1;
                    phase_next    = PH_FIRST;
                    left_next     = 4'd0;
                end else begin
                    phase_next = PH_THIRD;
                    left_next  = data_byte[3:0];
                end
            end
            PH_THIRD: begin
                job.code[0]   = {left_reg, data_byte[7:6]};
                job.code[1]   = data_byte[5:0];
                job.two_codes = 1'b1;
                phase_next    = PH_FIRST;
                left_next     = 4'd0;
            end
            default: begin
                job.code[0] = data_byte[7:2];
                if (last_byte) begin
                    job.code[1]   = {data_byte[1:0], 4'b0000};
                    job.two_codes = 1'b1;
                    job.pads      = 2'd2;
                    phase_next    = PH_FIRST;
                    left_next     = 4'd0;
                end else begin
                    phase_next = PH_SECOND;
                    left_next  = {2'b00, data_byte[1:0]};
                end
            end
        endcase
    end

    // Group state advances only on an accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            left_reg  <= 4'd0;
        end else if (push) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

// File: src/b64e_queue.sv
// Short job queue between the front end and the character serializer.
module b64e_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  b64e_pkg::job_t    push_job,
    input  logic              pop,
    output b64e_pkg::job_t    head_job,
    output b64e_pkg::q_stat_t stat
);
    import b64e_pkg::*;

    job_t           mem_reg [QDepth];
    logic [QAw-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCw-1:0] count_reg;

    assign head_job   = mem_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.full  = (count_reg == QCw'(QDepth));
    assign stat.empty = (count_reg == '0);

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/b64e_back.sv
// Back end: head job to output register, one character per cycle unless stalled.
module b64e_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           head_valid,
    input  b64e_pkg::job_t head_job,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast
);
    import b64e_pkg::*;

    logic [1:0] pos_reg, pos_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic [1:0] end_pos;
    logic       emit;
    logic       is_code;

    assign m_tvalid = valid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;

    // Index of the final character of the head job
    assign end_pos = {1'b0, head_job.two_codes} + head_job.pads;
    assign emit    = head_valid && (!valid_reg || m_tready);
    assign pop     = emit && (pos_reg == end_pos);
    assign is_code = (pos_reg == 2'd0) || ((pos_reg == 2'd1) && head_job.two_codes);

    // Next character and output register load
    always_comb begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (emit) begin
            valid_next = 1'b1;
            char_next  = is_code ? enc_char(head_job.code[pos_reg[0]]) : PadChar;
            last_next  = head_job.last && (pos_reg == end_pos);
            pos_next   = (pos_reg == end_pos) ? 2'd0 : pos_reg + 2'd1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

// File: src/base64_stream_encoder.sv
// Top level: base64 encoder, one input byte per item, one ASCII character per result item.
// Each byte's job is queued before its first character loads the output register.
// The output register sends one character per cycle while the receiver is ready, so a byte
// yields 1 to 4 characters (two for the third byte of a group, about 4/3 on average).
// A 4-entry job queue lets input run ahead of the output during short stalls.
// Reset (aresetn low, synchronous) empties the queue and starts a new group.
module base64_stream_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast    // last_char
);
    import b64e_pkg::*;

`include "base64_stream_encoder_macros.svh"

    job_t    front_job;
    job_t    head_job;
    q_stat_t q_stat;
    logic    push;
    logic    pop;

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    b64e_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .job       (front_job)
    );

    b64e_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (front_job),
        .pop      (pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    b64e_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (!q_stat.empty),
        .head_job   (head_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // Pending jobs always keep the output register loaded
    `B64E_ASSERT_NEXT(a_pending_drives_out, !q_stat.empty, m_tvalid, "queued job but no output")
    // Fill count stays within the queue depth
    `B64E_ASSERT_IMPLY(a_count_in_range, 1'b1, q_stat.count <= QCw'(QDepth), "queue count overflow")
    // A job is only retired while the queue holds one
    `B64E_ASSERT_IMPLY(a_pop_not_empty, pop, !q_stat.empty, "pop from empty queue")

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the streaming base64 encoder.
module tb_top;
    import b64e_pkg::*;

    localparam int          IdleLimit = 3000;
    localparam int          HoldCycles = 80;
    localparam logic [511:0] Alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_item_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_tlast  = 1'b0;    // last_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_char
    logic       m_tlast;            // last_char

    // Predictor state: position in the 3-byte group and leftover low bits
    phase_t     grp_phase = PH_FIRST;
    logic [3:0] carry_bits = 4'd0;

    byte_item_t pending_bytes[$];
    char_item_t expected_chars[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req_cnt = 0;
    int hold_seen_cnt = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int n_bytes = 0;
    int n_msgs = 0;
    int n_chars = 0;
    int n_errors = 0;

    base64_stream_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Six-bit code to its ASCII character
    function automatic logic [7:0] b64_symbol(input logic [5:0] v);
        return Alphabet[8*(63 - int'(v)) +: 8];
    endfunction

    function automatic void queue_char(input logic [7:0] ch, input logic last);
        char_item_t c;
        c.ch   = ch;
        c.last = last;
        expected_chars.push_back(c);
    endfunction

    // Expected characters for one accepted byte; advances the group state
    function automatic void encode_byte(input logic [7:0] b, input logic last);
        case (grp_phase)
            PH_SECOND: begin
                queue_char(b64_symbol({carry_bits[1:0], b[7:4]}), 1'b0);
                if (last) begin
                    queue_char(b64_symbol({b[3:0], 2'b00}), 1'b0);
                    queue_char(PadChar, 1'b1);
                    grp_phase  = PH_FIRST;
                    carry_bits = 4'd0;
                end else begin
                    grp_phase  = PH_THIRD;
                    carry_bits = b[3:0];
                end
            end
            PH_THIRD: begin
                queue_char(b64_symbol({carry_bits, b[7:6]}), 1'b0);
                queue_char(b64_symbol(b[5:0]), last);
                grp_phase  = PH_FIRST;
                carry_bits = 4'd0;
            end
            default: begin
                // first byte of a group; unused phase code behaves the same
                queue_char(b64_symbol(b[7:2]), 1'b0);
                if (last) begin
                    queue_char(b64_symbol({b[1:0], 4'b0000}), 1'b0);
                    queue_char(PadChar, 1'b0);
                    queue_char(PadChar, 1'b1);
                    grp_phase  = PH_FIRST;
                    carry_bits = 4'd0;
                end else begin
                    grp_phase  = PH_SECOND;
                    carry_bits = {2'b00, b[1:0]};
                end
            end
        endcase
    endfunction

    // Byte driver: predicts on acceptance, offers the next pending byte
    always @(posedge aclk) begin
        byte_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                encode_byte(s_tdata, s_tlast);
                n_bytes++;
                if (s_tlast) n_msgs++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Character monitor and receiver backpressure
    always @(posedge aclk) begin
        char_item_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_chars++;
                if (expected_chars.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected char, expected none, got %h/%0b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata !== want.ch) begin
                        n_errors++;
                        $display("%0t: out_char mismatch, expected %h, got %h",
                                 $time, want.ch, m_tdata);
                    end
                    if (m_tlast !== want.last) begin
                        n_errors++;
                        $display("%0t: last_char mismatch, expected %0b, got %0b",
                                 $time, want.last, m_tlast);
                    end
                end
            end
            // long hold-off on request, else random stalls
            if (hold_seen_cnt != hold_req_cnt) begin
                hold_seen_cnt = hold_req_cnt;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: cycles without any handshake while work is outstanding
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (pending_bytes.size() > 0 || s_tvalid || expected_chars.size() > 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        byte_item_t it;
        it.data = b;
        it.last = last;
        pending_bytes.push_back(it);
    endtask

    // Random messages of 1 to 7 bytes, about n bytes in all
    task automatic push_messages(input int n);
        int len;
        int k;
        logic [7:0] b;
        while (n > 0) begin
            len = $urandom_range(7, 1);
            for (k = 0; k < len; k++) begin
                case ($urandom_range(9))
                    0: b = 8'h00;
                    1: b = 8'hFF;
                    default: b = 8'($urandom_range(255));
                endcase
                push_byte(b, k == len - 1);
            end
            n -= len;
        end
    endtask

    // Wait until every byte is sent and every character has come back
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_bytes.size() > 0 || s_tvalid || expected_chars.size() > 0);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: extremes, every group position as last byte, '+' and '/'
        tx_idle_pct = 14;
        rx_idle_pct = 87;
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b1);
        push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b1);
        push_byte(8'hFB, 1'b0); push_byte(8'hEF, 1'b0); push_byte(8'hBE, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b1);
        push_byte(8'h4D, 1'b0); push_byte(8'h61, 1'b0); push_byte(8'h6E, 1'b0);
        push_byte(8'hA5, 1'b1);
        push_byte(8'h55, 1'b0); push_byte(8'hAA, 1'b0); push_byte(8'h0F, 1'b0);
        push_byte(8'hF0, 1'b0); push_byte(8'h3C, 1'b1);
        wait_drained();

        // Random, slow receiver
        push_messages(20);
        wait_drained();

        // Random, slow sender
        tx_idle_pct = 87;
        rx_idle_pct = 14;
        push_messages(20);
        wait_drained();

        // Random, no idling
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        push_messages(20);
        wait_drained();

        // Receiver holds off while the sender keeps offering
        hold_req_cnt++;
        push_messages(12);
        wait_drained();

        repeat (20) @(negedge aclk);
        $display("Covered %0d bytes in %0d messages, %0d characters checked.",
                 n_bytes, n_msgs, n_chars);
        $display("Idling mixes: slow receiver, slow sender, none, long receiver hold-off.");
        if (n_errors == 0 && expected_chars.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d characters still expected",
                     n_errors, expected_chars.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
